/* src/vfr_pkg.sv */
// Shared constants, types and codes of the voxel frame rotator.
`timescale 1ns / 1ps
`default_nettype none

package vfr_pkg;

    // Cube geometry.
    localparam int SIDE_SIZE    = 5;
    localparam int LAYER_COUNT  = 5;
    localparam int CENTRE_POINT = 2;
    localparam int ROW_COUNT    = LAYER_COUNT * SIDE_SIZE;
    localparam int ROW_W        = $clog2(ROW_COUNT);
    localparam int COORD_MAX    = (SIDE_SIZE > LAYER_COUNT) ? SIDE_SIZE : LAYER_COUNT;
    localparam int COORD_W      = $clog2(COORD_MAX);

    // Field widths of the channels.
    localparam int LAYER_W = 3;
    localparam int INDEX_W = 3;
    localparam int VOXEL_W = SIDE_SIZE;

    // Configuration port.
    localparam int ANGLE_W     = 10;
    localparam int AXIS_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = ANGLE_W;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_ANGLE = 1'd0;
    localparam t_cfg_index CFG_AXIS  = 1'd1;

    // Rotation axis codes; the fourth code selects no axis.
    typedef logic [AXIS_W-1:0] t_axis;
    localparam t_axis AXIS_Z = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_X = 2'd2;

    // Rounded cosine or sine: -1, 0 or +1.
    typedef logic signed [1:0] t_unit;
    localparam t_unit UNIT_POS  = 2'sb01;
    localparam t_unit UNIT_ZERO = 2'sb00;
    localparam t_unit UNIT_NEG  = 2'sb11;

    // Rotation setup derived from the configuration registers.
    typedef struct packed {
        t_unit cos_u;
        t_unit sin_u;
        t_axis axis;
    } t_rot_cfg;

    // Target of one rotated voxel.
    typedef struct packed {
        logic                 hit;
        logic [ROW_W-1:0]     addr;
        logic [SIDE_SIZE-1:0] mask;
    } t_map;

endpackage

`default_nettype wire

/* src/vfr_in_if.sv */
// Input row channel of the voxel frame rotator.
`timescale 1ns / 1ps
`default_nettype none

interface vfr_in_if;
    logic                        valid;
    logic                        ready;
    logic [vfr_pkg::LAYER_W-1:0] row_layer;
    logic [vfr_pkg::INDEX_W-1:0] row_index;
    logic [vfr_pkg::VOXEL_W-1:0] row_voxels;
    logic                        last_row;

    modport source (output valid, output row_layer, output row_index,
                    output row_voxels, output last_row, input ready);
    modport sink (input valid, input row_layer, input row_index,
                  input row_voxels, input last_row, output ready);
endinterface

`default_nettype wire

/* src/vfr_out_if.sv */
// Output row channel of the voxel frame rotator.
`timescale 1ns / 1ps
`default_nettype none

interface vfr_out_if;
    logic                        valid;
    logic                        ready;
    logic [vfr_pkg::LAYER_W-1:0] out_layer;
    logic [vfr_pkg::INDEX_W-1:0] out_index;
    logic [vfr_pkg::VOXEL_W-1:0] out_voxels;
    logic                        out_last;

    modport source (output valid, output out_layer, output out_index,
                    output out_voxels, output out_last, input ready);
    modport sink (input valid, input out_layer, input out_index,
                  input out_voxels, input out_last, output ready);
endinterface

`default_nettype wire

/* src/vfr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module vfr_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/vfr_config.sv */
// Configuration registers and rounded cosine and sine of the rotation angle.
`timescale 1ns / 1ps
`default_nettype none

module vfr_config (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [vfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [vfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output vfr_pkg::t_rot_cfg                   o_cfg
);
    import vfr_pkg::*;

    localparam int RED_W = ANGLE_W + 1;
    localparam logic signed [RED_W-1:0] FULL_TURN = RED_W'(360);
    localparam logic signed [RED_W-1:0] TWO_TURNS = RED_W'(720);

    logic signed [ANGLE_W-1:0] r_angle;
    t_axis                     r_axis;
    logic signed [RED_W-1:0]   angle_ext;
    logic signed [RED_W-1:0]   angle_red;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_axis  <= AXIS_Z;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANGLE: r_angle <= i_cfg_data;
                CFG_AXIS:  r_axis  <= i_cfg_data[AXIS_W-1:0];
                default:   ;
            endcase
        end
    end

    // Reduce the angle into 0 to 359 degrees.
    assign angle_ext = RED_W'(r_angle);

    always_comb begin
        priority if (angle_ext < -FULL_TURN) begin
            angle_red = angle_ext + TWO_TURNS;
        end else if (angle_ext < 0) begin
            angle_red = angle_ext + FULL_TURN;
        end else if (angle_ext >= FULL_TURN) begin
            angle_red = angle_ext - FULL_TURN;
        end else begin
            angle_red = angle_ext;
        end
    end

    // Round cosine and sine to -1, 0 or +1, ties away from zero.
    always_comb begin
        priority if (angle_red <= RED_W'(60) || angle_red >= RED_W'(300)) begin
            o_cfg.cos_u = UNIT_POS;
        end else if (angle_red >= RED_W'(120) && angle_red <= RED_W'(240)) begin
            o_cfg.cos_u = UNIT_NEG;
        end else begin
            o_cfg.cos_u = UNIT_ZERO;
        end

        priority if (angle_red >= RED_W'(30) && angle_red <= RED_W'(150)) begin
            o_cfg.sin_u = UNIT_POS;
        end else if (angle_red >= RED_W'(210) && angle_red <= RED_W'(330)) begin
            o_cfg.sin_u = UNIT_NEG;
        end else begin
            o_cfg.sin_u = UNIT_ZERO;
        end

        o_cfg.axis = r_axis;
    end

endmodule

`default_nettype wire

/* src/vfr_mapper.sv */
// Maps one source voxel to its row and bit in the rotated frame.
`timescale 1ns / 1ps
`default_nettype none

module vfr_mapper (
    input  wire logic [vfr_pkg::COORD_W-1:0] i_x,
    input  wire logic [vfr_pkg::COORD_W-1:0] i_y,
    input  wire logic [vfr_pkg::COORD_W-1:0] i_z,
    input  vfr_pkg::t_rot_cfg                i_cfg,
    output vfr_pkg::t_map                    o_map
);
    import vfr_pkg::*;

    localparam int SW = COORD_W + 3;
    localparam logic signed [SW-1:0] CENTRE_S = SW'(CENTRE_POINT);
    localparam logic signed [SW-1:0] SIDE_S   = SW'(SIDE_SIZE);
    localparam logic signed [SW-1:0] LAYER_S  = SW'(LAYER_COUNT);

    logic signed [SW-1:0] ux, uy, uz;
    logic signed [SW-1:0] nx, ny, nz;
    logic                 axis_ok;

    // Product of a unit value and a small signed coordinate.
    function automatic logic signed [SW-1:0] scale(t_unit k, logic signed [SW-1:0] v);
        logic signed [SW-1:0] res;
        unique case (k)
            UNIT_POS: res = v;
            UNIT_NEG: res = -v;
            default:  res = '0;
        endcase
        return res;
    endfunction

    // Offsets from the centre.
    assign ux = $signed(SW'(i_x)) - CENTRE_S;
    assign uy = $signed(SW'(i_y)) - CENTRE_S;
    assign uz = $signed(SW'(i_z)) - CENTRE_S;

    // Rotated coordinates per axis.
    always_comb begin
        nx      = $signed(SW'(i_x));
        ny      = $signed(SW'(i_y));
        nz      = $signed(SW'(i_z));
        axis_ok = 1'b1;
        unique case (i_cfg.axis)
            AXIS_Z: begin
                nx = scale(i_cfg.cos_u, ux) - scale(i_cfg.sin_u, uy) + CENTRE_S;
                ny = scale(i_cfg.sin_u, ux) + scale(i_cfg.cos_u, uy) + CENTRE_S;
            end
            AXIS_Y: begin
                nx = scale(i_cfg.cos_u, uz) + scale(i_cfg.sin_u, ux) + CENTRE_S;
                nz = scale(i_cfg.cos_u, ux) - scale(i_cfg.sin_u, uz) + CENTRE_S;
            end
            AXIS_X: begin
                ny = scale(i_cfg.cos_u, uz) - scale(i_cfg.sin_u, uy) + CENTRE_S;
                nz = scale(i_cfg.sin_u, uz) + scale(i_cfg.cos_u, uy) + CENTRE_S;
            end
            default: axis_ok = 1'b0;
        endcase
    end

    // Drop targets outside the cube and form the row address and bit.
    assign o_map.hit = axis_ok
                     && nx >= 0 && nx < SIDE_S
                     && ny >= 0 && ny < SIDE_S
                     && nz >= 0 && nz < LAYER_S;
    assign o_map.addr = ROW_W'(ROW_W'(nz[COORD_W-1:0]) * ROW_W'(SIDE_SIZE)
                        + ROW_W'(ny[COORD_W-1:0]));
    assign o_map.mask = SIDE_SIZE'(1) << nx[COORD_W-1:0];

endmodule

`default_nettype wire

/* src/voxel_frame_rotator.sv */
// Voxel frame rotator: row loader, rotation sequencer over two RAMs, row emitter.
// After the last row is accepted the rotator does one source read, one voxel step per
// voxel, one write drain and one RAM read before it offers the first rotated row, and
// one RAM read before each further row; each row waits for the receiver to take it.
// Rows are taken only while idle and are only stored until the last row; the voxel loop
// sets the pace of a 25-row frame with one read-modify-write of the rotated RAM per voxel.
// Reset clears control state and the configuration; the source RAM is undefined.
`timescale 1ns / 1ps
`default_nettype none

module voxel_frame_rotator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [vfr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [vfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vfr_in_if.sink                               i_row,
    vfr_out_if.source                            o_out
);
    import vfr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_READ      = 6'b000010,
        S_VOX       = 6'b000100,
        S_DRAIN     = 6'b001000,
        S_EMIT_RD   = 6'b010000,
        S_EMIT_SHOW = 6'b100000
    } t_state;

    localparam logic [COORD_W-1:0] X_LAST   = COORD_W'(SIDE_SIZE - 1);
    localparam logic [COORD_W-1:0] Y_LAST   = COORD_W'(SIDE_SIZE - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(ROW_COUNT - 1);

    t_state               r_state, n_state;
    logic [COORD_W-1:0]   r_x, n_x, r_y, n_y, r_z, n_z;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [ROW_COUNT-1:0] r_vld;
    logic                 r_s1_valid, n_s1_valid;
    logic [ROW_W-1:0]     r_s1_addr;
    logic [SIDE_SIZE-1:0] r_s1_mask;
    logic                 r_fwd_valid;
    logic [ROW_W-1:0]     r_fwd_addr;
    logic [SIDE_SIZE-1:0] r_fwd_data;

    t_rot_cfg             rot_cfg;
    t_map                 map;
    logic                 in_xfer, out_xfer;
    logic                 in_range;
    logic [ROW_W-1:0]     in_addr;
    logic [ROW_W-1:0]     row_next;
    logic                 row_end;
    logic                 src_re;
    logic [ROW_W-1:0]     src_raddr;
    logic [SIDE_SIZE-1:0] src_rdata;
    logic                 lit;
    logic                 rot_re;
    logic [ROW_W-1:0]     rot_raddr;
    logic [SIDE_SIZE-1:0] rot_rdata;
    logic [SIDE_SIZE-1:0] rot_base;
    logic [SIDE_SIZE-1:0] rot_merged;

    // Configuration registers.
    vfr_config u_config (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (rot_cfg)
    );

    // Input transfer and the source row address.
    assign i_row.ready = (r_state == S_IDLE);
    assign in_xfer     = i_row.valid && i_row.ready;
    assign in_range    = (int'(i_row.row_layer) < LAYER_COUNT)
                      && (int'(i_row.row_index) < SIDE_SIZE);
    assign in_addr     = ROW_W'(ROW_W'(i_row.row_layer) * ROW_W'(SIDE_SIZE)
                         + ROW_W'(i_row.row_index));

    // Source RAM: read once per row, the next row prefetched on the last voxel.
    assign row_next  = ROW_W'(r_row + ROW_W'(1));
    assign row_end   = (r_x == X_LAST);
    assign src_re    = (r_state == S_READ)
                    || (r_state == S_VOX && row_end && r_row != ROW_LAST);
    assign src_raddr = (r_state == S_READ) ? r_row : row_next;

    vfr_ram #(.WIDTH(SIDE_SIZE), .DEPTH(ROW_COUNT)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && in_range),
        .i_waddr (in_addr),
        .i_wdata (i_row.row_voxels),
        .i_re    (src_re),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    // Target of the current voxel.
    vfr_mapper u_mapper (
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .i_cfg (rot_cfg),
        .o_map (map)
    );

    assign lit = src_rdata[r_x];

    // Rotated RAM: read the target row, merge the voxel, write it back in the next cycle.
    assign rot_re    = (r_state == S_VOX) || (r_state == S_EMIT_RD);
    assign rot_raddr = (r_state == S_EMIT_RD) ? r_row : map.addr;

    // The write of the previous cycle is not yet in the read data, so forward it.
    always_comb begin
        if (r_fwd_valid && r_fwd_addr == r_s1_addr) begin
            rot_base = r_fwd_data;
        end else if (r_vld[r_s1_addr]) begin
            rot_base = rot_rdata;
        end else begin
            rot_base = '0;
        end
    end
    assign rot_merged = rot_base | r_s1_mask;

    vfr_ram #(.WIDTH(SIDE_SIZE), .DEPTH(ROW_COUNT)) u_rot_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (rot_merged),
        .i_re    (rot_re),
        .i_raddr (rot_raddr),
        .o_rdata (rot_rdata)
    );

    // Output row; rows never written since the clear read as zero.
    assign out_xfer         = o_out.valid && o_out.ready;
    assign o_out.valid      = (r_state == S_EMIT_SHOW);
    assign o_out.out_layer  = LAYER_W'(r_z);
    assign o_out.out_index  = INDEX_W'(r_y);
    assign o_out.out_voxels = r_vld[r_row] ? rot_rdata : '0;
    assign o_out.out_last   = (r_row == ROW_LAST);

    // Sequencer: load, scan voxels, drain, emit.
    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_row      = r_row;
        n_s1_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && i_row.last_row) begin
                    n_state = S_READ;
                    n_x     = '0;
                    n_y     = '0;
                    n_z     = '0;
                    n_row   = '0;
                end
            end
            S_READ: begin
                n_state = S_VOX;
            end
            S_VOX: begin
                n_s1_valid = lit && map.hit;
                if (row_end) begin
                    n_x = '0;
                    if (r_row == ROW_LAST) begin
                        n_state = S_DRAIN;
                        n_y     = '0;
                        n_z     = '0;
                        n_row   = '0;
                    end else begin
                        n_row = row_next;
                        if (r_y == Y_LAST) begin
                            n_y = '0;
                            n_z = COORD_W'(r_z + COORD_W'(1));
                        end else begin
                            n_y = COORD_W'(r_y + COORD_W'(1));
                        end
                    end
                end else begin
                    n_x = COORD_W'(r_x + COORD_W'(1));
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_SHOW;
            end
            S_EMIT_SHOW: begin
                if (out_xfer) begin
                    if (r_row == ROW_LAST) begin
                        n_state = S_IDLE;
                        n_y     = '0;
                        n_z     = '0;
                        n_row   = '0;
                    end else begin
                        n_state = S_EMIT_RD;
                        n_row   = row_next;
                        if (r_y == Y_LAST) begin
                            n_y = '0;
                            n_z = COORD_W'(r_z + COORD_W'(1));
                        end else begin
                            n_y = COORD_W'(r_y + COORD_W'(1));
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_row       <= n_row;
            r_s1_valid  <= n_s1_valid;
            r_fwd_valid <= r_s1_valid;
            // The rotated frame is cleared when a rotation starts.
            if (in_xfer && i_row.last_row) begin
                r_vld <= '0;
            end else if (r_s1_valid) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
        end
    end

    // Voxel pipeline and forwarding payload.
    always_ff @(posedge i_clk) begin
        r_s1_addr  <= map.addr;
        r_s1_mask  <= map.mask;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= rot_merged;
    end

    // A merge write only follows a voxel step.
    a_s1_after_vox: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(r_state == S_VOX))
        else $error("voxel write without a voxel step");

    // Merge writes stay inside the frame.
    a_s1_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_addr <= ROW_LAST))
        else $error("voxel write outside the frame");

    // No input is taken while a rotated row is offered.
    a_no_load_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_row.ready)
        else $error("input ready while emitting");

    // The last row transfer ends the frame.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.out_last) |=> (r_state == S_IDLE))
        else $error("frame did not end after the last row");

    // No write is pending when emission begins.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD) |-> !r_s1_valid)
        else $error("rotated RAM write pending at emission");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the voxel frame rotator with a built-in rotation predictor.
`timescale 1ns / 1ps

module tb_top;

    import vfr_pkg::*;

    // Run control.
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int ITEM_TARGET   = 430;

    // Idle percentages and the accepted-row counts where the idle pattern changes.
    localparam int IDLE_LOW     = 33;
    localparam int IDLE_HIGH    = 82;
    localparam int MODE_SPLIT_A = 150;
    localparam int MODE_SPLIT_B = 300;

    // The fourth axis code selects no axis, so every voxel is dropped.
    localparam t_axis AXIS_NONE = 2'd3;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [INDEX_W-1:0] index;
        logic [VOXEL_W-1:0] voxels;
        logic               last;
    } t_row_item;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ANGLE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   stall_request = 1'b0;

    vfr_in_if  row_if ();
    vfr_out_if out_if ();

    voxel_frame_rotator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_row       (row_if),
        .o_out       (out_if)
    );

    // Predictor state: the loaded frame and the register copies.
    logic [VOXEL_W-1:0] frame_rows [ROW_COUNT];
    logic [ANGLE_W-1:0] angle_reg;
    t_axis              axis_reg;

    t_row_item row_backlog[$];
    t_row_item expected_rows[$];

    int in_count    = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    int hold_cnt    = 0;
    bit hold_used   = 1'b0;

    // Directed settings that each rotate the frame already loaded.
    int dir_angles [10] = '{90, 30, 60, 180, -90, 360, -360, 511, -512, 45};
    t_axis dir_axes [10] = '{AXIS_Z, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X,
                             AXIS_Z, AXIS_Y, AXIS_Z, AXIS_X, AXIS_NONE};
    t_row_item dir_rows [10] = '{
        '{3'd2, 3'd2, 5'b10101, 1'b1},
        '{3'd5, 3'd0, 5'b11111, 1'b1},
        '{3'd0, 3'd5, 5'b11111, 1'b1},
        '{3'd4, 3'd4, 5'b11111, 1'b1},
        '{3'd0, 3'd0, 5'b00000, 1'b1},
        '{3'd4, 3'd0, 5'b00001, 1'b1},
        '{3'd0, 3'd4, 5'b10000, 1'b1},
        '{3'd3, 3'd1, 5'b01010, 1'b1},
        '{3'd1, 3'd3, 5'b00100, 1'b1},
        '{3'd2, 3'd2, 5'b11111, 1'b1}
    };

    // Angles on and around the points where the rounded sine and cosine change.
    int boundary_angles[$] = '{0, 29, 30, 31, 59, 60, 61, 89, 90, 119, 120, 121, 149, 150,
                               151, 180, 209, 210, 211, 239, 240, 241, 270, 299, 300, 301,
                               329, 330, 331, 359, 360, -360, -1, -30, -60, -90, -120,
                               -150, -180, -210, -240, -270, -300, -330, 511, -512};

    // Clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Stores one accepted row; a last row rotates the frame and queues all its rows.
    function automatic void rotate_and_store(t_row_item r);
        logic [VOXEL_W-1:0] rotated [ROW_COUNT];
        t_row_item res;
        int a, c, s, ux, uy, uz, nx, ny, nz;
        if (r.layer < LAYER_COUNT && r.index < SIDE_SIZE)
            frame_rows[r.layer * SIDE_SIZE + r.index] = r.voxels;
        if (!r.last)
            return;

        // Reduce the signed angle into 0..359 and round sine and cosine to units.
        a = int'($signed(angle_reg)) % 360;
        if (a < 0)
            a += 360;
        c = (a <= 60 || a >= 300) ? 1 : ((a >= 120 && a <= 240) ? -1 : 0);
        s = (a >= 30 && a <= 150) ? 1 : ((a >= 210 && a <= 330) ? -1 : 0);

        foreach (rotated[k])
            rotated[k] = '0;
        for (int z = 0; z < LAYER_COUNT; z++) begin
            for (int y = 0; y < SIDE_SIZE; y++) begin
                for (int x = 0; x < SIDE_SIZE; x++) begin
                    if (frame_rows[z * SIDE_SIZE + y][x]) begin
                        ux = x - CENTRE_POINT;
                        uy = y - CENTRE_POINT;
                        uz = z - CENTRE_POINT;
                        case (axis_reg)
                            AXIS_Z: begin
                                nx = c * ux - s * uy + CENTRE_POINT;
                                ny = s * ux + c * uy + CENTRE_POINT;
                                nz = z;
                            end
                            AXIS_Y: begin
                                nx = c * uz + s * ux + CENTRE_POINT;
                                ny = y;
                                nz = -s * uz + c * ux + CENTRE_POINT;
                            end
                            AXIS_X: begin
                                nx = x;
                                ny = c * uz - s * uy + CENTRE_POINT;
                                nz = s * uz + c * uy + CENTRE_POINT;
                            end
                            default: begin
                                nx = -1;
                                ny = -1;
                                nz = -1;
                            end
                        endcase
                        // Voxels that leave the cube are dropped; collisions merge.
                        if (nx >= 0 && nx < SIDE_SIZE && ny >= 0 && ny < SIDE_SIZE &&
                            nz >= 0 && nz < LAYER_COUNT)
                            rotated[nz * SIDE_SIZE + ny][nx] = 1'b1;
                    end
                end
            end
        end

        for (int z = 0; z < LAYER_COUNT; z++) begin
            for (int y = 0; y < SIDE_SIZE; y++) begin
                res.layer  = LAYER_W'(z);
                res.index  = INDEX_W'(y);
                res.voxels = rotated[z * SIDE_SIZE + y];
                res.last   = (z == LAYER_COUNT - 1) && (y == SIDE_SIZE - 1);
                expected_rows.push_back(res);
            end
        end
    endfunction

    function automatic int sender_idle_pct();
        if (in_count < MODE_SPLIT_A)
            return IDLE_LOW;
        if (in_count < MODE_SPLIT_B)
            return IDLE_HIGH;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (in_count < MODE_SPLIT_A)
            return IDLE_HIGH;
        if (in_count < MODE_SPLIT_B)
            return IDLE_LOW;
        return 0;
    endfunction

    // Mostly in-range positions, now and then any position the fields can hold.
    function automatic t_row_item random_row(bit last);
        t_row_item r;
        if ($urandom_range(9) != 0) begin
            r.layer = LAYER_W'($urandom_range(LAYER_COUNT - 1));
            r.index = INDEX_W'($urandom_range(SIDE_SIZE - 1));
        end else begin
            r.layer = LAYER_W'($urandom_range((1 << LAYER_W) - 1));
            r.index = INDEX_W'($urandom_range((1 << INDEX_W) - 1));
        end
        r.voxels = VOXEL_W'($urandom_range((1 << VOXEL_W) - 1));
        r.last   = last;
        return r;
    endfunction

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_ANGLE)
            angle_reg = data[ANGLE_W-1:0];
        else
            axis_reg = data[AXIS_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Both registers; the axis write carries random upper data bits.
    task automatic set_rotation(int angle, t_axis axis);
        logic [CFG_DATA_W-1:0] axis_data;
        axis_data = CFG_DATA_W'($urandom);
        axis_data[AXIS_W-1:0] = axis;
        write_reg(CFG_ANGLE, CFG_DATA_W'(angle));
        write_reg(CFG_AXIS, axis_data);
    endtask

    // Waits until every row is sent and every rotated row is back, then settles.
    task automatic wait_idle(int settle);
        while (row_backlog.size() != 0 || row_if.valid || expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Row driver: offers the next queued row once the current one has transferred.
    always @(posedge i_clk) begin : row_driver
        t_row_item nxt;
        if (!i_rst_n) begin
            row_if.valid <= 1'b0;
        end else begin
            if (row_if.valid && row_if.ready) begin
                rotate_and_store('{row_if.row_layer, row_if.row_index,
                                   row_if.row_voxels, row_if.last_row});
                in_count <= in_count + 1;
            end
            if (!row_if.valid || row_if.ready) begin
                if (row_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    nxt = row_backlog.pop_front();
                    row_if.row_layer  <= nxt.layer;
                    row_if.row_index  <= nxt.index;
                    row_if.row_voxels <= nxt.voxels;
                    row_if.last_row   <= nxt.last;
                    row_if.valid      <= 1'b1;
                end else begin
                    row_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_used <= 1'b0;
        end else if (stall_request && !hold_used) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result checker: compares each transfer with the oldest expected row.
    always @(posedge i_clk) begin : out_checker
        t_row_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected row: layer %0d index %0d voxels %b last %b",
                                 $realtime, out_if.out_layer, out_if.out_index,
                                 out_if.out_voxels, out_if.out_last);
                end else begin
                    want = expected_rows.pop_front();
                    if (out_if.out_layer !== want.layer || out_if.out_index !== want.index ||
                        out_if.out_voxels !== want.voxels || out_if.out_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: row mismatch: expected layer %0d index %0d %s",
                                     $realtime, want.layer, want.index,
                                     $sformatf("voxels %b last %b", want.voxels, want.last));
                            $display("%0t: row mismatch: got layer %0d index %0d %s",
                                     $realtime, out_if.out_layer, out_if.out_index,
                                     $sformatf("voxels %b last %b", out_if.out_voxels,
                                               out_if.out_last));
                        end
                    end
                end
            end
            out_if.ready <= (hold_cnt == 0) && ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d rows still expected",
                     cycle_count, expected_rows.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        t_row_item r;
        int sent;
        int frames;
        int rows;
        int angle;
        bit stall_armed;
        sent        = 0;
        stall_armed = 1'b0;

        row_if.valid      = 1'b0;
        row_if.row_layer  = '0;
        row_if.row_index  = '0;
        row_if.row_voxels = '0;
        row_if.last_row   = 1'b0;
        out_if.ready      = 1'b0;
        foreach (frame_rows[k])
            frame_rows[k] = '0;
        angle_reg = '0;
        axis_reg  = AXIS_Z;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every row once at the reset setting, so no later rotation reads an unwritten row.
        for (int k = 0; k < ROW_COUNT; k++) begin
            r.layer  = LAYER_W'(k / SIDE_SIZE);
            r.index  = INDEX_W'(k % SIDE_SIZE);
            r.voxels = VOXEL_W'((k == ROW_COUNT - 1) ? 31 : (k * 11) % 32);
            r.last   = (k == ROW_COUNT - 1);
            row_backlog.push_back(r);
        end
        sent += ROW_COUNT;
        wait_idle(SETTLE_CYCLES);

        // Directed settings: each axis, angle extremes and ties, the unused axis code,
        // out-of-range positions that still start a rotation.
        for (int k = 0; k < 10; k++) begin
            set_rotation(dir_angles[k], dir_axes[k]);
            if (k == 0) begin
                row_backlog.push_back('{3'd7, 3'd7, 5'b11111, 1'b0});
                sent++;
            end
            row_backlog.push_back(dir_rows[k]);
            sent++;
            wait_idle(SETTLE_CYCLES);
        end

        // Random settings, each followed by a few frames that end in a last row.
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(1) == 0)
                angle = boundary_angles[$urandom_range(boundary_angles.size() - 1)];
            else
                angle = int'($urandom_range(1023)) - 512;
            set_rotation(angle, t_axis'($urandom_range(3)));
            frames = $urandom_range(1, 3);

            // Once the sender runs flat out, block the output so the block backs up.
            if (!stall_armed && in_count >= MODE_SPLIT_B) begin
                stall_armed = 1'b1;
                stall_request <= 1'b1;
                frames = 3;
            end

            for (int f = 0; f < frames; f++) begin
                if (stall_request || (stall_armed && frames == 3 && !hold_used))
                    rows = 6;
                else if ($urandom_range(9) == 0)
                    rows = $urandom_range(13, 25);
                else
                    rows = $urandom_range(1, 8);
                for (int n = 0; n < rows; n++)
                    row_backlog.push_back(random_row(n == rows - 1));
                sent += rows;
            end
            wait_idle(SETTLE_CYCLES);
        end

        wait_idle(DRAIN_CYCLES);
        if (expected_rows.size() != 0) begin
            mismatches++;
            $display("%0d expected rows never arrived", expected_rows.size());
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
